// ----- rtl/core/ray_box_slab_intersect_assert.svh -----
// Assertion macros for the checker module of the ray/box slab test.
// Needs clk and rst in the scope where a macro is used.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rbs_pkg.sv -----
// Shared types and codes for the ray/box slab intersection block.
// No dependencies.
package rbs_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 6;
  localparam int REG_IDX_W = 3;

  typedef enum logic [2:0] {
    REG_BOX_LO_X = 3'd0,
    REG_BOX_HI_X = 3'd1,
    REG_BOX_LO_Y = 3'd2,
    REG_BOX_HI_Y = 3'd3,
    REG_BOX_LO_Z = 3'd4,
    REG_BOX_HI_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    axis_t axis;
    logic  neg;
  } nrm_t;

  localparam logic REQ_EXIT = 1'b1;

endpackage

// ----- rtl/core/ray_box_slab_intersect.sv -----
// Ray segment against an axis-aligned box (slab test), signed fixed point.
// Depends on rbs_pkg, rbs_div_cell and rbs_slab_stage.
//
// Takes one ray per clock while in_ready is high and returns one result
// beat per ray, in order. The pipeline is one input stage, a chain of
// COORD_WIDTH + FRAC_BITS + 1 division cells that each produce one quotient
// bit of all six slab bounds, a sign stage, one stage per axis, a segment
// clamp stage, a multiply stage and the output register. A two-entry output
// buffer lets the pipeline run while a result waits, so in_ready drops only
// after two results are held. Box registers must be written only while no
// ray is in flight.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rbs_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [COORD_WIDTH-1:0] seg_start,
  input  logic signed [COORD_WIDTH-1:0] seg_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] t_hit,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z,
  output logic [1:0]                    normal_axis,
  output logic                          normal_negative
);
  import rbs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int NW   = CW + FB + 1;
  localparam int CVW  = NW + 2;
  localparam int RW   = 1 + 8 * CW;
  localparam int SW   = RW + 12;
  localparam int QOFF = NUM_LANES * CVW;
  localparam int PW   = RW + 6 + QOFF;
  localparam int SUMW = 2 * CW + 1;
  localparam int OW   = 4 * CW + 4;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CVW-1:0] UNB_LO = {1'b1, {(CVW-1){1'b0}}};
  localparam logic signed [CVW-1:0] UNB_HI = {1'b0, {(CVW-1){1'b1}}};

  function automatic logic signed [CW-1:0] sat_cv(input logic signed [CVW-1:0] v);
    if (v[CVW-1:CW-1] == '0 || v[CVW-1:CW-1] == '1) begin
      return v[CW-1:0];
    end
    return v[CVW-1] ? MINV : MAXV;
  endfunction

  function automatic logic signed [CW-1:0] sat_sum(input logic signed [SUMW-1:0] v);
    if (v[SUMW-1:CW-1] == '0 || v[SUMW-1:CW-1] == '1) begin
      return v[CW-1:0];
    end
    return v[SUMW-1] ? MINV : MAXV;
  endfunction

  // Box bounds, indexed like the register map: lower/upper per axis.
  logic signed [CW-1:0] box [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        box[k] <= '0;
      end
    end else if (cfg_we && cfg_index <= REG_BOX_HI_Z) begin
      box[cfg_index] <= cfg_wdata;
    end
  end

  logic en;
  logic sk_valid;
  assign en       = ~sk_valid;
  assign in_ready = en;

  // Input stage: numerator magnitudes, divisor magnitudes and quotient signs.
  logic signed [CW-1:0] org_a [NUM_AXES];
  logic signed [CW-1:0] dir_a [NUM_AXES];
  assign org_a[0] = origin_x;
  assign org_a[1] = origin_y;
  assign org_a[2] = origin_z;
  assign dir_a[0] = dir_x;
  assign dir_a[1] = dir_y;
  assign dir_a[2] = dir_z;

  logic [RW-1:0] pr_ray;
  assign pr_ray = {req_type, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   seg_start, seg_end};

  logic signed [CW:0]           pr_diff [NUM_LANES];
  logic [CW:0]                  pr_mag  [NUM_LANES];
  logic [NUM_LANES-1:0][NW-1:0] pr_nq;
  logic [NUM_LANES-1:0][CW-1:0] pr_d;
  logic [NUM_LANES-1:0]         pr_neg;
  logic [NUM_AXES-1:0]          pr_zero, pr_zmiss;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      pr_diff[k] = $signed({box[k][CW-1], box[k]})
                 - $signed({org_a[k/2][CW-1], org_a[k/2]});
      pr_mag[k]  = pr_diff[k][CW] ? -pr_diff[k] : pr_diff[k];
      pr_nq[k]   = {pr_mag[k], {FB{1'b0}}};
      pr_d[k]    = dir_a[k/2][CW-1] ? -dir_a[k/2] : dir_a[k/2];
      pr_neg[k]  = pr_diff[k][CW] ^ dir_a[k/2][CW-1];
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      pr_zero[i]  = (dir_a[i] == '0);
      pr_zmiss[i] = (org_a[i] < box[2*i]) || (org_a[i] > box[2*i+1]);
    end
  end

  logic                         p_valid;
  logic [NUM_LANES-1:0][NW-1:0] p_nq;
  logic [NUM_LANES-1:0][CW-1:0] p_d;
  logic [SW-1:0]                p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_nq   <= pr_nq;
      p_d    <= pr_d;
      p_side <= {pr_ray, pr_neg, pr_zero, pr_zmiss};
    end
  end

  // Division chain.
  logic                         ch_valid [NW+1];
  logic [NUM_LANES-1:0][CW-1:0] ch_rem   [NW+1];
  logic [NUM_LANES-1:0][NW-1:0] ch_nq    [NW+1];
  logic [NUM_LANES-1:0][CW-1:0] ch_d     [NW+1];
  logic [SW-1:0]                ch_side  [NW+1];

  assign ch_valid[0] = p_valid;
  assign ch_rem[0]   = '0;
  assign ch_nq[0]    = p_nq;
  assign ch_d[0]     = p_d;
  assign ch_side[0]  = p_side;

  for (genvar g = 0; g < NW; g++) begin : g_div
    rbs_div_cell #(.CW(CW), .NW(NW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (ch_valid[g]),
      .in_rem   (ch_rem[g]),
      .in_nq    (ch_nq[g]),
      .in_d     (ch_d[g]),
      .in_side  (ch_side[g]),
      .out_valid(ch_valid[g+1]),
      .out_rem  (ch_rem[g+1]),
      .out_nq   (ch_nq[g+1]),
      .out_d    (ch_d[g+1]),
      .out_side (ch_side[g+1])
    );
  end

  // Sign stage: quotients truncated toward zero.
  logic [NUM_LANES-1:0][CVW-1:0] fx_q;
  logic [NUM_LANES-1:0]          fx_neg;
  assign fx_neg = ch_side[NW][11:6];

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      fx_q[k] = fx_neg[k] ? -{2'b00, ch_nq[NW][k]} : {2'b00, ch_nq[NW][k]};
    end
  end

  logic          f_valid;
  logic [PW-1:0] f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= ch_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side <= {ch_side[NW][SW-1:12], ch_side[NW][5:0], fx_q};
    end
  end

  // Per-axis cover update.
  logic                  sl_valid [NUM_AXES+1];
  logic [PW-1:0]         sl_side  [NUM_AXES+1];
  logic signed [CVW-1:0] sl_lo    [NUM_AXES+1];
  logic signed [CVW-1:0] sl_hi    [NUM_AXES+1];
  nrm_t                  sl_nrm   [NUM_AXES+1];
  logic                  sl_miss  [NUM_AXES+1];

  assign sl_valid[0] = f_valid;
  assign sl_side[0]  = f_side;
  assign sl_lo[0]    = UNB_LO;
  assign sl_hi[0]    = UNB_HI;
  assign sl_nrm[0]   = '{axis: AXIS_X, neg: 1'b0};
  assign sl_miss[0]  = 1'b0;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_slab
    rbs_slab_stage #(.CVW(CVW), .PW(PW), .AXIS(axis_t'(a))) u_slab (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sl_valid[a]),
      .in_side   (sl_side[a]),
      .qa        ($signed(sl_side[a][(2*a)*CVW +: CVW])),
      .qb        ($signed(sl_side[a][(2*a+1)*CVW +: CVW])),
      .zero      (sl_side[a][QOFF+3+a]),
      .zmiss     (sl_side[a][QOFF+a]),
      .exit_req  (sl_side[a][PW-1]),
      .in_cov_lo (sl_lo[a]),
      .in_cov_hi (sl_hi[a]),
      .in_nrm    (sl_nrm[a]),
      .in_miss   (sl_miss[a]),
      .out_valid (sl_valid[a+1]),
      .out_side  (sl_side[a+1]),
      .out_cov_lo(sl_lo[a+1]),
      .out_cov_hi(sl_hi[a+1]),
      .out_nrm   (sl_nrm[a+1]),
      .out_miss  (sl_miss[a+1])
    );
  end

  // Segment clamp and contact parameter.
  logic [RW-1:0]         g_ray;
  logic signed [CW-1:0]  g_ss, g_se;
  logic signed [CVW-1:0] seg_lo, seg_hi, t_wide;
  logic                  g_exit, g_hit_next;

  assign g_ray  = sl_side[NUM_AXES][PW-1 -: RW];
  assign g_exit = g_ray[RW-1];
  assign g_ss   = g_ray[CW +: CW];
  assign g_se   = g_ray[0 +: CW];
  assign seg_lo = {{(CVW-CW){g_ss[CW-1]}}, g_ss};
  assign seg_hi = {{(CVW-CW){g_se[CW-1]}}, g_se};

  always_comb begin
    g_hit_next = ~sl_miss[NUM_AXES] && (sl_lo[NUM_AXES] <= seg_hi)
                 && (seg_lo <= sl_hi[NUM_AXES]);
    if (g_exit == REQ_EXIT) begin
      t_wide = (sl_hi[NUM_AXES] < seg_hi) ? sl_hi[NUM_AXES] : seg_hi;
    end else begin
      t_wide = (sl_lo[NUM_AXES] > seg_lo) ? sl_lo[NUM_AXES] : seg_lo;
    end
  end

  logic                 g_valid, g_hit;
  logic signed [CW-1:0] g_t;
  nrm_t                 g_nrm;
  logic signed [CW-1:0] g_org [NUM_AXES];
  logic signed [CW-1:0] g_dir [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= sl_valid[NUM_AXES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_hit <= g_hit_next;
      g_t   <= sat_cv(t_wide);
      g_nrm <= sl_nrm[NUM_AXES];
      for (int i = 0; i < NUM_AXES; i++) begin
        g_org[i] <= g_ray[(7-i)*CW +: CW];
        g_dir[i] <= g_ray[(4-i)*CW +: CW];
      end
    end
  end

  // Contact point products.
  logic                   m_valid, m_hit;
  logic signed [CW-1:0]   m_t;
  nrm_t                   m_nrm;
  logic signed [CW-1:0]   m_org  [NUM_AXES];
  logic signed [2*CW-1:0] m_prod [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit <= g_hit;
      m_t   <= g_t;
      m_nrm <= g_nrm;
      for (int i = 0; i < NUM_AXES; i++) begin
        m_org[i]  <= g_org[i];
        m_prod[i] <= g_t * g_dir[i];
      end
    end
  end

  logic signed [2*CW-1:0] m_sh  [NUM_AXES];
  logic signed [SUMW-1:0] m_sum [NUM_AXES];
  logic signed [CW-1:0]   m_pt  [NUM_AXES];
  logic [OW-1:0]          res_next;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      m_sh[i]  = m_prod[i] >>> FB;
      m_sum[i] = $signed({{(CW+1){m_org[i][CW-1]}}, m_org[i]})
               + $signed({m_sh[i][2*CW-1], m_sh[i]});
      m_pt[i]  = sat_sum(m_sum[i]);
    end
    if (m_hit) begin
      res_next = {1'b1, m_t, m_pt[0], m_pt[1], m_pt[2], m_nrm.axis, m_nrm.neg};
    end else begin
      res_next = '0;
    end
  end

  // Output register with a skid entry behind it.
  logic [OW-1:0] out_q, sk_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (out_ready) begin
        out_q    <= sk_q;
        sk_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= m_valid;
      out_q     <= res_next;
    end else if (m_valid) begin
      sk_valid <= 1'b1;
      sk_q     <= res_next;
    end
  end

  assign normal_negative = out_q[0];
  assign normal_axis     = out_q[2:1];
  assign point_z         = out_q[3 +: CW];
  assign point_y         = out_q[3+CW +: CW];
  assign point_x         = out_q[3+2*CW +: CW];
  assign t_hit           = out_q[3+3*CW +: CW];
  assign hit             = out_q[OW-1];

endmodule

// ----- rtl/core/rbs_div_cell.sv -----
// One restoring-division step for all six slab quotients of a ray.
// Depends on rbs_pkg.
module rbs_div_cell #(
  parameter int CW = 32,
  parameter int NW = 49,
  parameter int SW = 269
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [rbs_pkg::NUM_LANES-1:0][CW-1:0]      in_rem,
  input  logic [rbs_pkg::NUM_LANES-1:0][NW-1:0]      in_nq,
  input  logic [rbs_pkg::NUM_LANES-1:0][CW-1:0]      in_d,
  input  logic [SW-1:0]                              in_side,
  output logic                                       out_valid,
  output logic [rbs_pkg::NUM_LANES-1:0][CW-1:0]      out_rem,
  output logic [rbs_pkg::NUM_LANES-1:0][NW-1:0]      out_nq,
  output logic [rbs_pkg::NUM_LANES-1:0][CW-1:0]      out_d,
  output logic [SW-1:0]                              out_side
);
  import rbs_pkg::*;

  logic [CW:0]   r2   [NUM_LANES];
  logic [CW+1:0] diff [NUM_LANES];
  logic [NUM_LANES-1:0][CW-1:0] rem_next;
  logic [NUM_LANES-1:0][NW-1:0] nq_next;

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      r2[k]       = {in_rem[k], in_nq[k][NW-1]};
      diff[k]     = {1'b0, r2[k]} - {2'b00, in_d[k]};
      rem_next[k] = diff[k][CW+1] ? r2[k][CW-1:0] : diff[k][CW-1:0];
      nq_next[k]  = {in_nq[k][NW-2:0], ~diff[k][CW+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_nq   <= nq_next;
      out_d    <= in_d;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/core/rbs_slab_stage.sv -----
// Intersects one axis slab with the running t cover and tracks the normal.
// Depends on rbs_pkg.
module rbs_slab_stage #(
  parameter int            CVW  = 51,
  parameter int            PW   = 569,
  parameter rbs_pkg::axis_t AXIS = rbs_pkg::AXIS_X
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [PW-1:0]         in_side,
  input  logic signed [CVW-1:0] qa,
  input  logic signed [CVW-1:0] qb,
  input  logic                  zero,
  input  logic                  zmiss,
  input  logic                  exit_req,
  input  logic signed [CVW-1:0] in_cov_lo,
  input  logic signed [CVW-1:0] in_cov_hi,
  input  rbs_pkg::nrm_t         in_nrm,
  input  logic                  in_miss,
  output logic                  out_valid,
  output logic [PW-1:0]         out_side,
  output logic signed [CVW-1:0] out_cov_lo,
  output logic signed [CVW-1:0] out_cov_hi,
  output rbs_pkg::nrm_t         out_nrm,
  output logic                  out_miss
);
  import rbs_pkg::*;

  localparam logic signed [CVW-1:0] UNB_LO = {1'b1, {(CVW-1){1'b0}}};
  localparam logic signed [CVW-1:0] UNB_HI = {1'b0, {(CVW-1){1'b1}}};

  logic signed [CVW-1:0] a, b, lo_next, hi_next;
  logic                  swapped, miss_next;
  nrm_t                  nrm_next;

  always_comb begin
    if (zero) begin
      a       = UNB_LO;
      b       = UNB_HI;
      swapped = 1'b0;
    end else if (qb < qa) begin
      a       = qb;
      b       = qa;
      swapped = 1'b1;
    end else begin
      a       = qa;
      b       = qb;
      swapped = 1'b0;
    end

    miss_next = in_miss | (zero & zmiss) | ~((in_cov_lo <= b) && (a <= in_cov_hi));
    lo_next   = in_cov_lo;
    hi_next   = in_cov_hi;
    nrm_next  = in_nrm;
    if (in_cov_lo < a) begin
      lo_next = a;
      if (exit_req != REQ_EXIT) begin
        nrm_next.axis = AXIS;
        nrm_next.neg  = ~swapped;
      end
    end
    if (b < in_cov_hi) begin
      hi_next = b;
      if (exit_req == REQ_EXIT) begin
        nrm_next.axis = AXIS;
        nrm_next.neg  = swapped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side   <= in_side;
      out_cov_lo <= lo_next;
      out_cov_hi <= hi_next;
      out_nrm    <= nrm_next;
      out_miss   <= miss_next;
    end
  end

endmodule

// ----- rtl/core/rbs_checker.sv -----
// Port-level checks for the ray/box slab intersection block, bound to its top.
// Depends on ray_box_slab_intersect_assert.svh.
`include "ray_box_slab_intersect_assert.svh"

module rbs_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   hit,
  input logic [COORD_WIDTH-1:0] t_hit,
  input logic [COORD_WIDTH-1:0] point_x,
  input logic [1:0]             normal_axis,
  input logic                   normal_negative
);

  // Input side stalls only when both the output register and skid entry hold a beat.
  `RBS_ASSERT_NOW(a_stall_needs_output, !in_ready, out_valid, "in_ready low with no output beat")

  `RBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(t_hit) && $stable(hit), "stalled output beat changed")

  `RBS_ASSERT_NOW(a_miss_zero, out_valid && !hit, t_hit == '0 && point_x == '0 && normal_axis == 2'd0 && !normal_negative, "miss beat carries nonzero fields")

  `RBS_ASSERT_NOW(a_axis_range, out_valid, normal_axis != 2'd3, "normal axis out of range")

endmodule

bind ray_box_slab_intersect rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (.*);
